// ----- src/iblf_pkg.sv -----
// iblf_pkg: shared constants, command codes and the token type for the ip block list filter
// used by iblf_issue, iblf_cell and ip_block_list_filter_top; no dependencies
package iblf_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W     = 32;
  localparam int ENT_W      = 7;
  localparam int CMD_W      = 2;
  localparam int SEL_W      = 2;
  localparam int IN_USER_W  = CMD_W + SEL_W;
  localparam int OUT_DATA_W = 2 + 2 * ENT_W;

  localparam logic [CMD_W-1:0] CMD_CHECK_IN  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK_OUT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADD       = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 2'd3;

  localparam logic [SEL_W-1:0] SEL_IN   = 2'd0;
  localparam logic [SEL_W-1:0] SEL_OUT  = 2'd1;
  localparam logic [SEL_W-1:0] SEL_BOTH = 2'd2;

  // one transaction as it walks down the cell chain
  typedef struct packed {
    logic              vld;
    logic              chk;
    logic              chk_out;
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W-1:0] addr;
    logic              wr_in;
    logic              wr_out;
    logic [IDX_W-1:0]  in_idx;
    logic [IDX_W-1:0]  out_idx;
    logic              hit;
    logic              status;
    logic [ENT_W-1:0]  in_entries;
    logic [ENT_W-1:0]  out_entries;
  } token_t;

endpackage

// ----- src/iblf_issue.sv -----
// iblf_issue: holds the list fill counts and turns an accepted transaction into a chain token
// depends on iblf_pkg
module iblf_issue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic [iblf_pkg::CMD_W-1:0]    cmd,
  input  logic [iblf_pkg::ADDR_W-1:0]   ip_addr,
  input  logic [iblf_pkg::SEL_W-1:0]    list_sel,
  output iblf_pkg::token_t              tok
);

  logic [iblf_pkg::CNT_W-1:0] in_count_r, in_count_nxt;
  logic [iblf_pkg::CNT_W-1:0] out_count_r, out_count_nxt;
  logic in_add, out_add, in_full, out_full, wr_in, wr_out, is_clear;

  always_comb begin
    is_clear = (cmd == iblf_pkg::CMD_CLEAR);
    in_add   = (cmd == iblf_pkg::CMD_ADD) &&
               ((list_sel == iblf_pkg::SEL_IN) || (list_sel == iblf_pkg::SEL_BOTH));
    out_add  = (cmd == iblf_pkg::CMD_ADD) &&
               ((list_sel == iblf_pkg::SEL_OUT) || (list_sel == iblf_pkg::SEL_BOTH));
    in_full  = (in_count_r >= iblf_pkg::CNT_W'(iblf_pkg::LIST_DEPTH));
    out_full = (out_count_r >= iblf_pkg::CNT_W'(iblf_pkg::LIST_DEPTH));
    wr_in    = in_add && !in_full;
    wr_out   = out_add && !out_full;

    if (is_clear) begin
      in_count_nxt  = '0;
      out_count_nxt = '0;
    end else begin
      in_count_nxt  = wr_in  ? in_count_r + 1'b1  : in_count_r;
      out_count_nxt = wr_out ? out_count_r + 1'b1 : out_count_r;
    end

    tok.vld         = acc;
    tok.chk         = (cmd == iblf_pkg::CMD_CHECK_IN) || (cmd == iblf_pkg::CMD_CHECK_OUT);
    tok.chk_out     = (cmd == iblf_pkg::CMD_CHECK_OUT);
    // count seen by a check at the moment it is issued
    tok.cnt         = (cmd == iblf_pkg::CMD_CHECK_OUT) ? out_count_r : in_count_r;
    tok.addr        = ip_addr;
    tok.wr_in       = acc && wr_in;
    tok.wr_out      = acc && wr_out;
    tok.in_idx      = in_count_r[iblf_pkg::IDX_W-1:0];
    tok.out_idx     = out_count_r[iblf_pkg::IDX_W-1:0];
    tok.hit         = 1'b0;
    tok.status      = (in_add && in_full) || (out_add && out_full);
    tok.in_entries  = iblf_pkg::ENT_W'(in_count_nxt);
    tok.out_entries = iblf_pkg::ENT_W'(out_count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_count_r  <= '0;
      out_count_r <= '0;
    end else if (acc) begin
      in_count_r  <= in_count_nxt;
      out_count_r <= out_count_nxt;
    end
  end

endmodule

// ----- src/iblf_cell.sv -----
// iblf_cell: one slot of both block lists; compares the passing token and forwards it
// depends on iblf_pkg
module iblf_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic [iblf_pkg::IDX_W-1:0]   cell_idx,
  input  iblf_pkg::token_t             tok_i,
  output iblf_pkg::token_t             tok_o
);

  logic [iblf_pkg::ADDR_W-1:0] in_entry_r;
  logic [iblf_pkg::ADDR_W-1:0] out_entry_r;
  logic [iblf_pkg::ADDR_W-1:0] entry;
  logic                        in_range, match;
  iblf_pkg::token_t            tok_r, tok_nxt;

  always_comb begin
    entry    = tok_i.chk_out ? out_entry_r : in_entry_r;
    // slots at or above the issue-time count are not held entries
    in_range = (iblf_pkg::CNT_W'(cell_idx) < tok_i.cnt);
    match    = tok_i.chk && in_range && (entry == tok_i.addr);
    tok_nxt     = tok_i;
    tok_nxt.hit = tok_i.hit | match;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  // adds ride the chain behind earlier checks, so writes land in order
  always_ff @(posedge clk) begin
    if (adv && tok_i.vld && tok_i.wr_in && (tok_i.in_idx == cell_idx)) begin
      in_entry_r <= tok_i.addr;
    end
    if (adv && tok_i.vld && tok_i.wr_out && (tok_i.out_idx == cell_idx)) begin
      out_entry_r <= tok_i.addr;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- src/ip_block_list_filter_top.sv -----
// ip_block_list_filter_top: ipv4 block list filter, issue stage plus a chain of list cells
// depends on iblf_pkg, iblf_issue and iblf_cell
//
// Each transaction (check incoming, check outgoing, add, clear) walks down a chain of
// LIST_DEPTH cells, one cell per list slot, moving one cell per cycle; the result comes
// out of the last cell, and a new transaction is taken every cycle. The whole chain
// holds while a result at the output is not taken, and in_tready then stays low.
// Fill counts are kept at the issue stage, so a clear takes effect at once for all
// later transactions; a full list makes an add report status 1 and skip that list.
module ip_block_list_filter_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [iblf_pkg::ADDR_W-1:0]        in_tdata,   // [31:0] ip_addr
  input  logic [iblf_pkg::IN_USER_W-1:0]     in_tuser,   // [1:0] cmd, [3:2] list_sel
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] verdict, [1] status, [8:2] in_entries, [15:9] out_entries
  output logic [iblf_pkg::OUT_DATA_W-1:0]    out_tdata
);

  iblf_pkg::token_t tok_chain [iblf_pkg::LIST_DEPTH+1];
  logic             adv;
  logic             acc;

  assign adv       = !tok_chain[iblf_pkg::LIST_DEPTH].vld || out_tready;
  assign in_tready = adv;
  assign acc       = in_tvalid && adv;

  iblf_issue u_issue (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .cmd      (in_tuser[iblf_pkg::CMD_W-1:0]),
    .ip_addr  (in_tdata),
    .list_sel (in_tuser[iblf_pkg::IN_USER_W-1:iblf_pkg::CMD_W]),
    .tok      (tok_chain[0])
  );

  for (genvar k = 0; k < iblf_pkg::LIST_DEPTH; k++) begin : g_cell
    iblf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (iblf_pkg::IDX_W'(k)),
      .tok_i    (tok_chain[k]),
      .tok_o    (tok_chain[k+1])
    );
  end

  assign out_tvalid = tok_chain[iblf_pkg::LIST_DEPTH].vld;
  assign out_tdata  = {tok_chain[iblf_pkg::LIST_DEPTH].out_entries,
                       tok_chain[iblf_pkg::LIST_DEPTH].in_entries,
                       tok_chain[iblf_pkg::LIST_DEPTH].status,
                       tok_chain[iblf_pkg::LIST_DEPTH].hit};

  // a drop verdict only comes from a check, a full flag only from an add
  a_verdict_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("verdict and status both set");

  // an add that wrote every list it selected cannot report full
  a_status_skips_write: assert property (@(posedge clk) disable iff (!rst_n)
    tok_chain[0].vld && tok_chain[0].status |-> !(tok_chain[0].wr_in && tok_chain[0].wr_out))
    else $error("full status with both inserts done");

  // a stalled chain keeps its first stage occupancy
  a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(tok_chain[1].vld))
    else $error("chain moved while stalled");

endmodule

// ----- sim/tb_ip_block_list_filter_top.sv -----
// tb_ip_block_list_filter_top: self-checking testbench for the ipv4 block list filter
// depends on iblf_pkg and ip_block_list_filter_top; a directed table, then random
// command episodes, every result checked against a behavioral list model or a typed value
`timescale 1ns / 1ps

module tb_ip_block_list_filter_top;
  import iblf_pkg::*;

  localparam int TOTAL_ITEMS  = 1850;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 500;
  localparam int DIR_N        = 24;

  typedef struct packed {
    logic             verdict;
    logic             status;
    logic [ENT_W-1:0] in_e;
    logic [ENT_W-1:0] out_e;
  } filter_resp_t;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [SEL_W-1:0]  sel;
    bit                typed;
    filter_resp_t      resp;
  } dir_row_t;

  localparam filter_resp_t ZERO_RESP = '0;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [ADDR_W-1:0]     in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  // list model
  logic [ADDR_W-1:0] blocked_in  [LIST_DEPTH];
  logic [ADDR_W-1:0] blocked_out [LIST_DEPTH];
  int                n_in;
  int                n_out;

  filter_resp_t      expected_q [$];
  logic [ADDR_W-1:0] added_addrs [$];
  dir_row_t          dir_rows [DIR_N];

  int items_sent;
  int results_seen;
  int mismatches;
  int idle_cycles;
  int tx_calm;
  int rx_calm;
  int ep_left;
  bit ep_fill;
  bit first_ep;

  ip_block_list_filter_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic filter_resp_t apply_filter_cmd(input logic [CMD_W-1:0] cmd,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [SEL_W-1:0] sel);
    filter_resp_t r;
    r = '0;
    case (cmd)
      CMD_CHECK_IN: begin
        for (int k = 0; k < n_in; k++)
          if (blocked_in[k] == addr) r.verdict = 1'b1;
      end
      CMD_CHECK_OUT: begin
        for (int k = 0; k < n_out; k++)
          if (blocked_out[k] == addr) r.verdict = 1'b1;
      end
      CMD_ADD: begin
        if (sel == SEL_IN || sel == SEL_BOTH) begin
          if (n_in >= LIST_DEPTH) begin
            r.status = 1'b1;
          end else begin
            blocked_in[n_in] = addr;
            n_in++;
          end
        end
        if (sel == SEL_OUT || sel == SEL_BOTH) begin
          if (n_out >= LIST_DEPTH) begin
            r.status = 1'b1;
          end else begin
            blocked_out[n_out] = addr;
            n_out++;
          end
        end
      end
      default: begin
        n_in  = 0;
        n_out = 0;
      end
    endcase
    r.in_e  = ENT_W'(n_in);
    r.out_e = ENT_W'(n_out);
    return r;
  endfunction

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr(input bit for_add);
    int r;
    r = $urandom_range(0, 9);
    if (added_addrs.size() > 0 && r < (for_add ? 2 : 5))
      return added_addrs[$urandom_range(0, added_addrs.size() - 1)];
    if (r == 5)
      return $urandom_range(0, 1) ? '1 : '0;
    // near miss: a held address with one bit flipped
    if (r == 6 && added_addrs.size() > 0)
      return added_addrs[$urandom_range(0, added_addrs.size() - 1)]
             ^ (ADDR_W'(1) << $urandom_range(0, ADDR_W - 1));
    return $urandom();
  endfunction

  // episodes of mixed traffic or add-heavy fill runs, usually closed by a clear
  task automatic next_random_cmd(output logic [CMD_W-1:0] cmd,
                                 output logic [ADDR_W-1:0] addr,
                                 output logic [SEL_W-1:0] sel);
    int roll;
    int add_pct;
    int s;
    if (ep_left == 0) begin
      ep_fill  = first_ep || ($urandom_range(0, 2) == 0);
      first_ep = 1'b0;
      ep_left  = $urandom_range(80, 300);
    end
    ep_left--;
    roll    = $urandom_range(0, 99);
    add_pct = ep_fill ? 75 : 30;
    if (ep_left == 0 && $urandom_range(0, 4) != 0)
      cmd = CMD_CLEAR;
    else if (roll < add_pct)
      cmd = CMD_ADD;
    else if (!ep_fill && roll == 99)
      cmd = CMD_CLEAR;
    else if (roll < add_pct + (99 - add_pct) / 2)
      cmd = CMD_CHECK_IN;
    else
      cmd = CMD_CHECK_OUT;
    if (cmd == CMD_ADD) begin
      s = $urandom_range(0, 9);
      sel = (s < 3) ? SEL_IN : (s < 6) ? SEL_OUT : (s < 9) ? SEL_BOTH : SEL_W'(3);
      addr = pick_addr(1'b1);
      added_addrs.push_back(addr);
      if (added_addrs.size() > 128) void'(added_addrs.pop_front());
    end else begin
      sel  = SEL_W'($urandom_range(0, 3));
      addr = pick_addr(1'b0);
    end
  endtask

  task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                            input logic [SEL_W-1:0] sel, input bit typed,
                            input filter_resp_t typed_resp);
    int gap;
    filter_resp_t pred;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    in_tuser  <= {sel, cmd};
    do @(posedge clk); while (in_tready !== 1'b1);
    pred = apply_filter_cmd(cmd, addr, sel);
    expected_q.push_back(typed ? typed_resp : pred);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic report_field(input string fname, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
    end
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] data);
    filter_resp_t exp_r;
    if (expected_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected transaction, expected none, actual %h", $time, data);
    end else begin
      exp_r = expected_q.pop_front();
      report_field("verdict", exp_r.verdict, data[0]);
      report_field("status", exp_r.status, data[1]);
      report_field("in_entries", exp_r.in_e, data[8:2]);
      report_field("out_entries", exp_r.out_e, data[15:9]);
    end
  endtask

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result side
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = draw_gap(rx_calm);
      // one long hold-off so the chain fills and in_tready drops
      if (results_seen == HOLD_AT) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      check_result(out_tdata);
      results_seen++;
      @(negedge clk);
    end
  end

  // stimulus side
  initial begin
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [SEL_W-1:0]  sel;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    n_in        = 0;
    n_out       = 0;
    items_sent  = 0;
    results_seen = 0;
    mismatches  = 0;
    idle_cycles = 0;
    tx_calm     = 0;
    rx_calm     = 0;
    ep_left     = 0;
    first_ep    = 1'b1;
    dir_rows = '{
      '{CMD_CHECK_IN,  32'h0000_0000, SEL_IN,    1'b1, ZERO_RESP},
      '{CMD_CHECK_OUT, 32'hFFFF_FFFF, SEL_OUT,   1'b1, ZERO_RESP},
      '{CMD_ADD,       32'hFFFF_FFFF, SEL_IN,    1'b0, ZERO_RESP},
      '{CMD_ADD,       32'h0000_0000, SEL_OUT,   1'b0, ZERO_RESP},
      '{CMD_ADD,       32'hC0A8_0001, SEL_BOTH,  1'b0, ZERO_RESP},
      '{CMD_ADD,       32'h1234_5678, 2'd3,      1'b0, ZERO_RESP},
      '{CMD_CHECK_IN,  32'hFFFF_FFFF, SEL_IN,    1'b0, ZERO_RESP},
      '{CMD_CHECK_IN,  32'h0000_0000, SEL_IN,    1'b0, ZERO_RESP},
      '{CMD_CHECK_OUT, 32'h0000_0000, SEL_OUT,   1'b0, ZERO_RESP},
      '{CMD_CHECK_OUT, 32'hFFFF_FFFF, SEL_BOTH,  1'b0, ZERO_RESP},
      '{CMD_CHECK_IN,  32'hC0A8_0001, 2'd3,      1'b0, ZERO_RESP},
      '{CMD_CHECK_OUT, 32'hC0A8_0001, SEL_IN,    1'b0, ZERO_RESP},
      '{CMD_CHECK_IN,  32'h1234_5678, SEL_IN,    1'b0, ZERO_RESP},
      '{CMD_ADD,       32'hC0A8_0001, SEL_IN,    1'b0, ZERO_RESP},
      '{CMD_CHECK_IN,  32'hC0A8_0002, SEL_IN,    1'b0, ZERO_RESP},
      '{CMD_ADD,       32'h5555_5555, SEL_BOTH,  1'b0, ZERO_RESP},
      '{CMD_CHECK_OUT, 32'h5555_5555, SEL_OUT,   1'b0, ZERO_RESP},
      '{CMD_CHECK_IN,  32'hAAAA_AAAA, SEL_IN,    1'b0, ZERO_RESP},
      '{CMD_ADD,       32'h8000_0001, SEL_OUT,   1'b0, ZERO_RESP},
      '{CMD_CLEAR,     32'h7FFF_FFFE, SEL_IN,    1'b1, ZERO_RESP},
      '{CMD_CHECK_IN,  32'hFFFF_FFFF, SEL_IN,    1'b1, ZERO_RESP},
      '{CMD_CHECK_OUT, 32'h0000_0000, SEL_OUT,   1'b1, ZERO_RESP},
      '{CMD_CLEAR,     32'hFFFF_FFFF, 2'd3,      1'b1, ZERO_RESP},
      '{CMD_CHECK_OUT, 32'h8000_0001, 2'd3,      1'b1, ZERO_RESP}
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i])
      offer_item(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].sel,
                 dir_rows[i].typed, dir_rows[i].resp);
    while (items_sent < TOTAL_ITEMS) begin
      next_random_cmd(cmd, addr, sel);
      offer_item(cmd, addr, sel, 1'b0, ZERO_RESP);
    end
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/iblf_pkg.sv
src/iblf_issue.sv
src/iblf_cell.sv
src/ip_block_list_filter_top.sv
sim/tb_ip_block_list_filter_top.sv
